// ===== rtl/core/cqmi_pkg.sv =====
// Shared types and constants of the crossed-quad mesh indexer.
// Used by the channel interfaces and all rtl/core modules; no dependencies.
`default_nettype none

package cqmi_pkg;

  localparam int unsigned IDX_W   = 24;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned STEP_W  = 17;
  localparam int unsigned COORD_W = 17;
  localparam int unsigned CIDX_W  = 2;

  localparam logic [COORD_W-1:0] COORD_MAX = 17'h10000;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_TRI   = 2'd1,
    KIND_EDGE  = 2'd2,
    KIND_CELL  = 2'd3
  } kind_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_COLS   = 2'd0,
    CFG_ROWS   = 2'd1,
    CFG_STEP_X = 2'd2,
    CFG_STEP_Y = 2'd3
  } cfg_idx_e;

  // position of a record within one rectangle's burst
  typedef enum logic [4:0] {
    REC_P0     = 5'd0,
    REC_P1     = 5'd1,
    REC_P2     = 5'd2,
    REC_P3     = 5'd3,
    REC_P4     = 5'd4,
    REC_T0     = 5'd5,
    REC_T1     = 5'd6,
    REC_T2     = 5'd7,
    REC_T3     = 5'd8,
    REC_E0F    = 5'd9,
    REC_E0B    = 5'd10,
    REC_E1F    = 5'd11,
    REC_E1B    = 5'd12,
    REC_E2F    = 5'd13,
    REC_E2B    = 5'd14,
    REC_E3F    = 5'd15,
    REC_E3B    = 5'd16,
    REC_BOTTOM = 5'd17,
    REC_TOP    = 5'd18,
    REC_LEFT   = 5'd19,
    REC_RIGHT  = 5'd20
  } rec_e;

  typedef struct packed {
    logic [DIM_W-1:0]  cols;
    logic [DIM_W-1:0]  rows;
    logic [STEP_W-1:0] step_x;
    logic [STEP_W-1:0] step_y;
  } cfg_t;

  // one classified rectangle, ready for the record sequencer
  typedef struct packed {
    logic               oog;
    logic               j0;
    logic               jtop;
    logic               i0;
    logic               iright;
    logic [COORD_W-1:0] xl;
    logic [COORD_W-1:0] xr;
    logic [COORD_W-1:0] xc;
    logic [COORD_W-1:0] yb;
    logic [COORD_W-1:0] yt;
    logic [COORD_W-1:0] yc;
    logic [IDX_W-1:0]   ncell;
    logic [IDX_W-1:0]   p0;
    logic [IDX_W-1:0]   p1;
    logic [IDX_W-1:0]   p2;
    logic [IDX_W-1:0]   p3;
    logic [IDX_W-1:0]   p4;
    logic [IDX_W-1:0]   slot_bot;
    logic [IDX_W-1:0]   slot_top;
    logic [IDX_W-1:0]   slot_left;
    logic [IDX_W-1:0]   slot_right;
    logic [IDX_W-1:0]   ev_bot;
    logic [IDX_W-1:0]   ev_top;
  } desc_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  typedef struct packed {
    kind_e            kind;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] first_value;
    logic [IDX_W-1:0] second_value;
    logic [IDX_W-1:0] third_value;
    logic             out_of_grid;
    logic             last;
  } rec_t;

  function automatic logic [COORD_W-1:0] sat_coord(input logic [27:0] v);
    logic [COORD_W-1:0] r;
    r = (v > 28'(COORD_MAX)) ? COORD_MAX : v[COORD_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cqmi_if.sv =====
// Valid/ready channel interfaces: configuration writes, rectangle words in,
// mesh record words out. Depends on cqmi_pkg.
`default_nettype none

interface cqmi_cfg_if;
  import cqmi_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [STEP_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface cqmi_in_if;
  import cqmi_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] col;
  logic [POS_W-1:0] row;
  modport source (output valid, col, row, input ready);
  modport sink (input valid, col, row, output ready);
endinterface

interface cqmi_out_if;
  import cqmi_pkg::*;
  logic             valid;
  logic             ready;
  kind_e            kind;
  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] first_value;
  logic [IDX_W-1:0] second_value;
  logic [IDX_W-1:0] third_value;
  logic             out_of_grid;
  logic             last;
  modport source (output valid, kind, slot, first_value, second_value, third_value,
                  out_of_grid, last, input ready);
  modport sink (input valid, kind, slot, first_value, second_value, third_value,
                out_of_grid, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cqmi_front.sv =====
// Front end: accepts rectangle words, computes indices and coordinates in
// two register stages and pushes one descriptor into the queue. Uses cqmi_pkg.
`default_nettype none

module cqmi_front #(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  cqmi_pkg::cfg_t       cfg_i,
  cqmi_in_if.sink              in_i,
  input  cqmi_pkg::q_stat_t    q_stat_i,
  output logic                 push_o,
  output cqmi_pkg::desc_t      push_desc_o
);
  import cqmi_pkg::*;

  typedef struct packed {
    logic              oog;
    logic [POS_W-1:0]  i;
    logic [POS_W-1:0]  j;
    logic [DIM_W-1:0]  nx;
    logic [DIM_W-1:0]  ny;
    logic [20:0]       jnx;
    logic [26:0]       x0;
    logic [26:0]       y0;
    logic [STEP_W-1:0] step_x;
    logic [STEP_W-1:0] step_y;
    logic [21:0]       nxny;
    logic [20:0]       pp;
  } sa_t;

  typedef struct packed {
    logic               oog;
    logic [POS_W-1:0]   i;
    logic [POS_W-1:0]   j;
    logic [DIM_W-1:0]   nx;
    logic [DIM_W-1:0]   ny;
    logic [IDX_W-1:0]   nrect;
    logic [IDX_W-1:0]   eb;
    logic [IDX_W-1:0]   a_top;
    logic [IDX_W-1:0]   a_lr;
    logic [IDX_W-1:0]   a_r;
    logic [20:0]        pp;
    logic [COORD_W-1:0] xl;
    logic [COORD_W-1:0] xr;
    logic [COORD_W-1:0] xc;
    logic [COORD_W-1:0] yb;
    logic [COORD_W-1:0] yt;
    logic [COORD_W-1:0] yc;
    logic               j0;
    logic               jtop;
    logic               i0;
    logic               iright;
  } sb_t;

  logic              a_valid_q, b_valid_q, en;
  sa_t               a_d, a_q;
  sb_t               b_d, b_q;
  logic [DIM_W-1:0]  nx, ny;
  logic [DIM_W:0]    nx1, ny1;
  logic [23:0]       pp_full;
  logic [IDX_W-1:0]  nxny24, nx24, ny24, i24, j24, nx4;

  // stall the whole front only when a finished descriptor has nowhere to go
  assign en         = !b_valid_q || !q_stat_i.full;
  assign in_i.ready = en;
  assign push_o     = b_valid_q && !q_stat_i.full;

  // stage A: clamp the grid and run the multiplies
  assign nx      = (cfg_i.cols > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cfg_i.cols;
  assign ny      = (cfg_i.rows > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : cfg_i.rows;
  assign nx1     = {1'b0, nx} + 12'd1;
  assign ny1     = {1'b0, ny} + 12'd1;
  assign pp_full = 24'(nx1) * 24'(ny1);

  always_comb begin
    a_d.oog    = ({1'b0, in_i.col} >= nx) || ({1'b0, in_i.row} >= ny);
    a_d.i      = in_i.col;
    a_d.j      = in_i.row;
    a_d.nx     = nx;
    a_d.ny     = ny;
    a_d.jnx    = 21'(in_i.row) * 21'(nx);
    a_d.x0     = 27'(in_i.col) * 27'(cfg_i.step_x);
    a_d.y0     = 27'(in_i.row) * 27'(cfg_i.step_y);
    a_d.step_x = cfg_i.step_x;
    a_d.step_y = cfg_i.step_y;
    a_d.nxny   = 22'(nx) * 22'(ny);
    a_d.pp     = pp_full[20:0];
  end

  // stage B: linear index, array bases, saturated coordinates, border flags
  assign nxny24 = IDX_W'(a_q.nxny);

  always_comb begin
    b_d.oog    = a_q.oog;
    b_d.i      = a_q.i;
    b_d.j      = a_q.j;
    b_d.nx     = a_q.nx;
    b_d.ny     = a_q.ny;
    b_d.nrect  = IDX_W'(a_q.i) + IDX_W'(a_q.jnx);
    b_d.eb     = {a_q.nxny[20:0], 3'b000};
    b_d.a_top  = {a_q.nxny[20:0], 3'b000} + nxny24 - IDX_W'(a_q.nx);
    b_d.a_lr   = {a_q.nxny[20:0], 3'b000} + {nxny24[22:0], 1'b0}
               - IDX_W'({a_q.nx, 1'b0});
    b_d.a_r    = {a_q.nxny[20:0], 3'b000} + {nxny24[22:0], 1'b0} + nxny24
               - IDX_W'({a_q.nx, 1'b0}) - IDX_W'(a_q.ny);
    b_d.pp     = a_q.pp;
    b_d.xl     = sat_coord(28'(a_q.x0));
    b_d.xr     = sat_coord(28'(a_q.x0) + 28'(a_q.step_x));
    b_d.xc     = sat_coord(28'(a_q.x0) + 28'(a_q.step_x[STEP_W-1:1]));
    b_d.yb     = sat_coord(28'(a_q.y0));
    b_d.yt     = sat_coord(28'(a_q.y0) + 28'(a_q.step_y));
    b_d.yc     = sat_coord(28'(a_q.y0) + 28'(a_q.step_y[STEP_W-1:1]));
    b_d.j0     = (a_q.j == '0);
    b_d.jtop   = ({1'b0, a_q.j} == a_q.ny - 11'd1);
    b_d.i0     = (a_q.i == '0);
    b_d.iright = ({1'b0, a_q.i} == a_q.nx - 11'd1);
  end

  // descriptor assembly from stage B
  assign nx24 = IDX_W'(b_q.nx);
  assign ny24 = IDX_W'(b_q.ny);
  assign i24  = IDX_W'(b_q.i);
  assign j24  = IDX_W'(b_q.j);
  assign nx4  = {nx24[21:0], 2'b00};

  always_comb begin
    push_desc_o.oog        = b_q.oog;
    push_desc_o.j0         = b_q.j0;
    push_desc_o.jtop       = b_q.jtop;
    push_desc_o.i0         = b_q.i0;
    push_desc_o.iright     = b_q.iright;
    push_desc_o.xl         = b_q.xl;
    push_desc_o.xr         = b_q.xr;
    push_desc_o.xc         = b_q.xc;
    push_desc_o.yb         = b_q.yb;
    push_desc_o.yt         = b_q.yt;
    push_desc_o.yc         = b_q.yc;
    push_desc_o.ncell      = {b_q.nrect[21:0], 2'b00};
    push_desc_o.p0         = b_q.nrect + j24;
    push_desc_o.p1         = b_q.nrect + j24 + nx24 + 24'd1;
    push_desc_o.p2         = b_q.nrect + j24 + nx24 + 24'd2;
    push_desc_o.p3         = b_q.nrect + j24 + 24'd1;
    push_desc_o.p4         = IDX_W'(b_q.pp) + b_q.nrect;
    push_desc_o.slot_bot   = b_q.j0 ? i24 : b_q.eb + b_q.nrect - nx24;
    push_desc_o.slot_top   = b_q.jtop ? nx24 + i24 : b_q.a_top + b_q.nrect;
    push_desc_o.slot_left  = b_q.i0 ? {nx24[22:0], 1'b0} + j24
                                    : b_q.a_lr + b_q.nrect - j24 - 24'd1;
    push_desc_o.slot_right = b_q.iright ? {nx24[22:0], 1'b0} + ny24 + j24
                                        : b_q.a_r + b_q.nrect - j24;
    push_desc_o.ev_bot     = {b_q.nrect[21:0], 2'b00} - nx4 + 24'd2;
    push_desc_o.ev_top     = {b_q.nrect[21:0], 2'b00} + nx4;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_i.valid;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cqmi_queue.sv =====
// Descriptor queue between front end and record sequencer.
// Small register FIFO with status struct. Uses cqmi_pkg.
`default_nettype none

module cqmi_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  cqmi_pkg::desc_t    push_desc_i,
  input  wire logic          pop_i,
  output cqmi_pkg::desc_t    head_o,
  output cqmi_pkg::q_stat_t  stat_o
);
  import cqmi_pkg::*;

  desc_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] count_q;

  assign head_o       = mem_q[rd_q];
  assign stat_o.count = count_q;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == QCNT_W'(QDEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_desc_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cqmi_back.sv =====
// Back end: walks the head descriptor through its records into the output register,
// one per cycle unless the output stalls. Uses cqmi_pkg.
`default_nettype none

module cqmi_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  cqmi_pkg::desc_t    head_i,
  input  cqmi_pkg::q_stat_t  stat_i,
  output logic               pop_o,
  cqmi_out_if.source         out_o
);
  import cqmi_pkg::*;

  rec_e             rec_d, rec_q;
  rec_t             rec, out_q;
  logic             out_valid_q, load, fin;
  logic [IDX_W-1:0] nc0, nc1, nc2, nc3, ebase;

  assign load  = !out_valid_q || out_o.ready;
  assign fin   = head_i.oog || (rec_q == REC_RIGHT);
  assign pop_o = load && !stat_i.empty && fin;

  assign nc0   = head_i.ncell;
  assign nc1   = head_i.ncell + 24'd1;
  assign nc2   = head_i.ncell + 24'd2;
  assign nc3   = head_i.ncell + 24'd3;
  assign ebase = {head_i.ncell[22:0], 1'b0};

  always_comb begin
    rec      = '0;
    rec.kind = KIND_POINT;
    if (head_i.oog) begin
      rec.out_of_grid = 1'b1;
      rec.last        = 1'b1;
    end else begin
      rec.last = (rec_q == REC_RIGHT);
      unique case (rec_q)
        REC_P0: begin
          rec.slot = head_i.p0;
          rec.first_value  = IDX_W'(head_i.xl);
          rec.second_value = IDX_W'(head_i.yb);
        end
        REC_P1: begin
          rec.slot = head_i.p1;
          rec.first_value  = IDX_W'(head_i.xl);
          rec.second_value = IDX_W'(head_i.yt);
        end
        REC_P2: begin
          rec.slot = head_i.p2;
          rec.first_value  = IDX_W'(head_i.xr);
          rec.second_value = IDX_W'(head_i.yt);
        end
        REC_P3: begin
          rec.slot = head_i.p3;
          rec.first_value  = IDX_W'(head_i.xr);
          rec.second_value = IDX_W'(head_i.yb);
        end
        REC_P4: begin
          rec.slot = head_i.p4;
          rec.first_value  = IDX_W'(head_i.xc);
          rec.second_value = IDX_W'(head_i.yc);
        end
        REC_T0: begin
          rec.kind = KIND_TRI;
          rec.slot = nc0;
          rec.first_value  = head_i.p0;
          rec.second_value = head_i.p3;
          rec.third_value  = head_i.p4;
        end
        REC_T1: begin
          rec.kind = KIND_TRI;
          rec.slot = nc1;
          rec.first_value  = head_i.p2;
          rec.second_value = head_i.p4;
          rec.third_value  = head_i.p3;
        end
        REC_T2: begin
          rec.kind = KIND_TRI;
          rec.slot = nc2;
          rec.first_value  = head_i.p2;
          rec.second_value = head_i.p1;
          rec.third_value  = head_i.p4;
        end
        REC_T3: begin
          rec.kind = KIND_TRI;
          rec.slot = nc3;
          rec.first_value  = head_i.p0;
          rec.second_value = head_i.p4;
          rec.third_value  = head_i.p1;
        end
        REC_E0F: begin
          rec.kind = KIND_EDGE;
          rec.slot = ebase;
          rec.first_value  = nc0;
          rec.second_value = nc1;
        end
        REC_E0B: begin
          rec.kind = KIND_EDGE;
          rec.slot = ebase + 24'd1;
          rec.first_value  = nc1;
          rec.second_value = nc0;
        end
        REC_E1F: begin
          rec.kind = KIND_EDGE;
          rec.slot = ebase + 24'd2;
          rec.first_value  = nc1;
          rec.second_value = nc2;
        end
        REC_E1B: begin
          rec.kind = KIND_EDGE;
          rec.slot = ebase + 24'd3;
          rec.first_value  = nc2;
          rec.second_value = nc1;
        end
        REC_E2F: begin
          rec.kind = KIND_EDGE;
          rec.slot = ebase + 24'd4;
          rec.first_value  = nc2;
          rec.second_value = nc3;
        end
        REC_E2B: begin
          rec.kind = KIND_EDGE;
          rec.slot = ebase + 24'd5;
          rec.first_value  = nc3;
          rec.second_value = nc2;
        end
        REC_E3F: begin
          rec.kind = KIND_EDGE;
          rec.slot = ebase + 24'd6;
          rec.first_value  = nc3;
          rec.second_value = nc0;
        end
        REC_E3B: begin
          rec.kind = KIND_EDGE;
          rec.slot = ebase + 24'd7;
          rec.first_value  = nc0;
          rec.second_value = nc3;
        end
        REC_BOTTOM: begin
          rec.slot        = head_i.slot_bot;
          rec.first_value = nc0;
          if (head_i.j0) begin
            rec.kind = KIND_CELL;
            rec.second_value = head_i.p0;
            rec.third_value  = head_i.p3;
          end else begin
            rec.kind = KIND_EDGE;
            rec.second_value = head_i.ev_bot;
          end
        end
        REC_TOP: begin
          rec.slot        = head_i.slot_top;
          rec.first_value = nc2;
          if (head_i.jtop) begin
            rec.kind = KIND_CELL;
            rec.second_value = head_i.p1;
            rec.third_value  = head_i.p2;
          end else begin
            rec.kind = KIND_EDGE;
            rec.second_value = head_i.ev_top;
          end
        end
        REC_LEFT: begin
          rec.slot        = head_i.slot_left;
          rec.first_value = nc3;
          if (head_i.i0) begin
            rec.kind = KIND_CELL;
            rec.second_value = head_i.p0;
            rec.third_value  = head_i.p1;
          end else begin
            rec.kind = KIND_EDGE;
            rec.second_value = nc0 - 24'd3;
          end
        end
        REC_RIGHT: begin
          rec.slot        = head_i.slot_right;
          rec.first_value = nc1;
          if (head_i.iright) begin
            rec.kind = KIND_CELL;
            rec.second_value = head_i.p2;
            rec.third_value  = head_i.p3;
          end else begin
            rec.kind = KIND_EDGE;
            rec.second_value = nc0 + 24'd7;
          end
        end
        default: begin
          rec.slot = '0;
        end
      endcase
    end
  end

  always_comb begin
    rec_d = rec_q;
    if (load && !stat_i.empty) begin
      rec_d = fin ? REC_P0 : rec_e'(rec_q + 5'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rec_q       <= REC_P0;
    end else begin
      rec_q <= rec_d;
      if (load) begin
        out_valid_q <= !stat_i.empty;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !stat_i.empty) begin
      out_q <= rec;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = out_q.kind;
  assign out_o.slot         = out_q.slot;
  assign out_o.first_value  = out_q.first_value;
  assign out_o.second_value = out_q.second_value;
  assign out_o.third_value  = out_q.third_value;
  assign out_o.out_of_grid  = out_q.out_of_grid;
  assign out_o.last         = out_q.last;

endmodule

`default_nettype wire

// ===== rtl/core/crossed_quad_mesh_indexer.sv =====
// Crossed-quad mesh indexer top: configuration registers, front end, queue, back end.
// Path of a record: front stages A and B, a queue entry, then the output register.
// An in-grid rectangle gives 21 records, an out-of-grid one gives 1; the back-end
// sequencer issues one record per cycle on the single output channel unless stalled.
// Input words flow into the front end and the 2-entry queue meanwhile until it fills.
// Reset: cols = rows = 1, step_x = step_y = 65536, pipeline and queue empty.
`default_nettype none

module crossed_quad_mesh_indexer #(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  cqmi_cfg_if.sink     cfg_i,
  cqmi_in_if.sink      in_i,
  cqmi_out_if.source   out_o
);
  import cqmi_pkg::*;

  cfg_t    cfg_q;
  desc_t   push_desc, head;
  q_stat_t q_stat;
  logic    push, pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cols   <= DIM_W'(1);
      cfg_q.rows   <= DIM_W'(1);
      cfg_q.step_x <= STEP_W'(65536);
      cfg_q.step_y <= STEP_W'(65536);
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_COLS:   cfg_q.cols   <= cfg_i.data[DIM_W-1:0];
        CFG_ROWS:   cfg_q.rows   <= cfg_i.data[DIM_W-1:0];
        CFG_STEP_X: cfg_q.step_x <= cfg_i.data;
        CFG_STEP_Y: cfg_q.step_y <= cfg_i.data;
        default:    cfg_q        <= cfg_q;
      endcase
    end
  end

  cqmi_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_desc_o (push_desc)
  );

  cqmi_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  cqmi_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .stat_i (q_stat),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  a_oog_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.out_of_grid |-> out_o.last)
    else $error("out-of-grid record not marked last");

  a_third_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind == KIND_POINT || out_o.kind == KIND_EDGE)
    |-> out_o.third_value == '0)
    else $error("point or edge record with nonzero third value");

  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("descriptor queue overflow");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("push into full queue");

endmodule

`default_nettype wire

// ===== tb/cqmi_mesh_checker.sv =====
// Record checker for the crossed-quad mesh indexer: tracks register writes,
// predicts the 21-word burst per in-grid rectangle (1 word if outside) and
// compares the output. Depends on cqmi_pkg and the cqmi_if.sv channel interfaces.
module cqmi_mesh_checker #(
  parameter int unsigned GRID_COLS = 1024,
  parameter int unsigned GRID_ROWS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cqmi_cfg_if         cfg_mon,
  cqmi_in_if          in_mon,
  cqmi_out_if         out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cqmi_pkg::*;

  logic [DIM_W-1:0]  cols_r;
  logic [DIM_W-1:0]  rows_r;
  logic [STEP_W-1:0] step_x_r;
  logic [STEP_W-1:0] step_y_r;

  rec_t        expected_records[$];
  int unsigned fails;
  rec_t        got_rec;
  rec_t        want_rec;

  function automatic rec_t make_rec(input kind_e k, input longint unsigned slot,
                                    input longint unsigned a, input longint unsigned b,
                                    input longint unsigned c);
    rec_t rec;
    rec.kind         = k;
    rec.slot         = slot[IDX_W-1:0];
    rec.first_value  = a[IDX_W-1:0];
    rec.second_value = b[IDX_W-1:0];
    rec.third_value  = c[IDX_W-1:0];
    rec.out_of_grid  = 1'b0;
    rec.last         = 1'b0;
    return rec;
  endfunction

  function automatic longint unsigned clip_coord(input longint unsigned v);
    return (v > 65536) ? 65536 : v;
  endfunction

  function automatic void build_rect_records(input logic [POS_W-1:0] c,
                                             input logic [POS_W-1:0] r);
    longint unsigned i, j, nx, ny, nrect, ncell, eb;
    longint unsigned p0, p1, p2, p3, p4;
    longint unsigned sx, sy, x0, y0, xl, xr, xc, yb, yt, yc;
    rec_t burst[$];
    i  = c;
    j  = r;
    nx = (cols_r > GRID_COLS) ? GRID_COLS : cols_r;
    ny = (rows_r > GRID_ROWS) ? GRID_ROWS : rows_r;
    if (i >= nx || j >= ny) begin
      burst.push_back(make_rec(KIND_POINT, 0, 0, 0, 0));
      burst[0].out_of_grid = 1'b1;
      burst[0].last        = 1'b1;
      expected_records.push_back(burst[0]);
      return;
    end
    nrect = i + j * nx;
    ncell = nrect * 4;
    p0 = j * (nx + 1) + i;
    p1 = (j + 1) * (nx + 1) + i;
    p2 = p1 + 1;
    p3 = p0 + 1;
    p4 = (nx + 1) * (ny + 1) + nx * j + i;
    sx = step_x_r;
    sy = step_y_r;
    x0 = i * sx;
    y0 = j * sy;
    xl = clip_coord(x0);
    xr = clip_coord(x0 + sx);
    xc = clip_coord(x0 + (sx >> 1));
    yb = clip_coord(y0);
    yt = clip_coord(y0 + sy);
    yc = clip_coord(y0 + (sy >> 1));

    burst.push_back(make_rec(KIND_POINT, p0, xl, yb, 0));
    burst.push_back(make_rec(KIND_POINT, p1, xl, yt, 0));
    burst.push_back(make_rec(KIND_POINT, p2, xr, yt, 0));
    burst.push_back(make_rec(KIND_POINT, p3, xr, yb, 0));
    burst.push_back(make_rec(KIND_POINT, p4, xc, yc, 0));

    burst.push_back(make_rec(KIND_TRI, ncell,     p0, p3, p4));
    burst.push_back(make_rec(KIND_TRI, ncell + 1, p2, p4, p3));
    burst.push_back(make_rec(KIND_TRI, ncell + 2, p2, p1, p4));
    burst.push_back(make_rec(KIND_TRI, ncell + 3, p0, p4, p1));

    // internal ring of the four triangles, both directions
    for (int k = 0; k < 4; k++) begin
      burst.push_back(make_rec(KIND_EDGE, nrect * 8 + k * 2, ncell + k,
                               (k == 3) ? ncell : ncell + k + 1, 0));
      burst.push_back(make_rec(KIND_EDGE, nrect * 8 + k * 2 + 1,
                               (k == 3) ? ncell : ncell + k + 1, ncell + k, 0));
    end

    eb = 8 * nx * ny;
    if (j != 0)
      burst.push_back(make_rec(KIND_EDGE, eb + nx * (j - 1) + i, ncell,
                               ncell - 4 * nx + 2, 0));
    else
      burst.push_back(make_rec(KIND_CELL, i, ncell, p0, p3));

    if (j != ny - 1)
      burst.push_back(make_rec(KIND_EDGE, eb + nx * (ny - 1) + nx * j + i,
                               ncell + 2, ncell + 4 * nx, 0));
    else
      burst.push_back(make_rec(KIND_CELL, nx + i, ncell + 2, p1, p2));

    if (i != 0)
      burst.push_back(make_rec(KIND_EDGE, eb + 2 * nx * (ny - 1) + (nx - 1) * j + i - 1,
                               ncell + 3, ncell - 3, 0));
    else
      burst.push_back(make_rec(KIND_CELL, 2 * nx + j, ncell + 3, p0, p1));

    if (i != nx - 1)
      burst.push_back(make_rec(KIND_EDGE,
                               eb + 2 * nx * (ny - 1) + (nx - 1) * ny + (nx - 1) * j + i,
                               ncell + 1, ncell + 7, 0));
    else
      burst.push_back(make_rec(KIND_CELL, 2 * nx + ny + j, ncell + 1, p2, p3));

    burst[burst.size() - 1].last = 1'b1;
    foreach (burst[n]) expected_records.push_back(burst[n]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_r   = 1;
      rows_r   = 1;
      step_x_r = 65536;
      step_y_r = 65536;
      expected_records.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_COLS:   cols_r   = cfg_mon.data[DIM_W-1:0];
          CFG_ROWS:   rows_r   = cfg_mon.data[DIM_W-1:0];
          CFG_STEP_X: step_x_r = cfg_mon.data;
          CFG_STEP_Y: step_y_r = cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        build_rect_records(in_mon.col, in_mon.row);
      if (out_mon.valid && out_mon.ready) begin
        got_rec.kind         = out_mon.kind;
        got_rec.slot         = out_mon.slot;
        got_rec.first_value  = out_mon.first_value;
        got_rec.second_value = out_mon.second_value;
        got_rec.third_value  = out_mon.third_value;
        got_rec.out_of_grid  = out_mon.out_of_grid;
        got_rec.last         = out_mon.last;
        if (expected_records.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected word kind=%0d slot=%0d", $realtime,
                     got_rec.kind, got_rec.slot);
        end else begin
          want_rec = expected_records.pop_front();
          if (got_rec.kind !== want_rec.kind || got_rec.slot !== want_rec.slot ||
              got_rec.first_value !== want_rec.first_value ||
              got_rec.second_value !== want_rec.second_value ||
              got_rec.third_value !== want_rec.third_value ||
              got_rec.out_of_grid !== want_rec.out_of_grid ||
              got_rec.last !== want_rec.last) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: word mismatch", $realtime);
              $display("  exp kind=%0d slot=%0d a=%0d b=%0d c=%0d oog=%0d last=%0d",
                       want_rec.kind, want_rec.slot, want_rec.first_value,
                       want_rec.second_value, want_rec.third_value,
                       want_rec.out_of_grid, want_rec.last);
              $display("  got kind=%0d slot=%0d a=%0d b=%0d c=%0d oog=%0d last=%0d",
                       got_rec.kind, got_rec.slot, got_rec.first_value,
                       got_rec.second_value, got_rec.third_value,
                       got_rec.out_of_grid, got_rec.last);
            end
          end
        end
      end
      pending_o    <= expected_records.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ===== tb/tb_crossed_quad_mesh_indexer.sv =====
// Top of the crossed-quad mesh indexer testbench: clock, reset, register
// loads, rectangle stimulus, output backpressure and the verdict.
// Depends on cqmi_pkg, cqmi_if.sv, the rtl/core sources and cqmi_mesh_checker.
module tb_crossed_quad_mesh_indexer;
  timeunit 1ns;
  timeprecision 1ps;
  import cqmi_pkg::*;

  localparam int unsigned GRID_MAX   = 1024;
  localparam int unsigned STALL_STOP = 3000;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles;
  int unsigned phase_no;
  bit          calm;
  bit          squeezed;
  int unsigned grid_cols;
  int unsigned grid_rows;

  cqmi_cfg_if cfg_ch ();
  cqmi_in_if  in_ch ();
  cqmi_out_if out_ch ();

  crossed_quad_mesh_indexer #(
    .MAX_COLS (GRID_MAX),
    .MAX_ROWS (GRID_MAX)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  cqmi_mesh_checker #(
    .GRID_COLS (GRID_MAX),
    .GRID_ROWS (GRID_MAX)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mon      (cfg_ch),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // no-progress watchdog
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((cfg_ch.valid && cfg_ch.ready) || (in_ch.valid && in_ch.ready) ||
          (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_STOP) begin
        $display("tb_crossed_quad_mesh_indexer failed");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // output backpressure: random bursts, one long hold, none at the end
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (calm) begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end else if (phase_no == 2 && !squeezed) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        squeezed = 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
        if ($urandom_range(0, 1) == 1) begin
          out_ch.ready <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk_i);
        end
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input int unsigned value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value[STEP_W-1:0];
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_rect(input int unsigned c, input int unsigned r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.col   <= c[POS_W-1:0];
    in_ch.row   <= r[POS_W-1:0];
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // wait for every expected word, then wait out an idle margin
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic load_grid(input int unsigned c, input int unsigned r,
                           input int unsigned sx, input int unsigned sy);
    settle();
    write_reg(CFG_COLS, c);
    write_reg(CFG_ROWS, r);
    write_reg(CFG_STEP_X, sx);
    write_reg(CFG_STEP_Y, sy);
    cfg_ch.valid <= 1'b0;
    grid_cols = (c > GRID_MAX) ? GRID_MAX : c;
    grid_rows = (r > GRID_MAX) ? GRID_MAX : r;
  endtask

  function automatic int unsigned pick_dim();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return $urandom_range(1, 6);
    if (roll < 8) return $urandom_range(1, GRID_MAX);
    if (roll == 8) return GRID_MAX;
    return $urandom_range(GRID_MAX + 1, 2047);
  endfunction

  function automatic int unsigned pick_step(input int unsigned dim);
    if ($urandom_range(0, 9) < 7) return 65536 / dim;
    return $urandom_range(0, 131071);
  endfunction

  // phase number is set once the grid is loaded, before words are offered
  task automatic random_phase(input int unsigned ph, input int unsigned n_items);
    int unsigned c, r;
    c = pick_dim();
    r = pick_dim();
    load_grid(c, r, pick_step(c), pick_step(r));
    phase_no = ph;
    for (int unsigned n = 0; n < n_items; n++) begin
      if ($urandom_range(0, 99) < 85)
        send_rect($urandom_range(0, grid_cols - 1), $urandom_range(0, grid_rows - 1));
      else
        send_rect($urandom_range(0, 1023), $urandom_range(0, 1023));
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    phase_no     = 0;
    calm         = 1'b0;
    grid_cols    = 1;
    grid_rows    = 1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_COLS;
    cfg_ch.data  <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.col    <= '0;
    in_ch.row    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset grid: single full-square rectangle
    send_rect(0, 0);
    send_rect(1, 0);
    send_rect(0, 1);
    send_rect(1023, 1023);

    // 3x2 grid covers corners, borders and outside on each axis
    load_grid(3, 2, 21845, 32768);
    for (int unsigned r = 0; r < 2; r++)
      for (int unsigned c = 0; c < 3; c++) send_rect(c, r);
    send_rect(3, 0);
    send_rect(0, 2);

    load_grid(1024, 1024, 64, 64);
    send_rect(0, 0);
    send_rect(1023, 1023);
    send_rect(1023, 0);
    send_rect(0, 1023);
    send_rect(512, 511);

    // oversized grid clamps; wide step saturates; zero step
    load_grid(2047, 2047, 131071, 0);
    send_rect(1023, 1023);
    send_rect(5, 7);

    load_grid(1, 1024, 1, 65535);
    send_rect(0, 1023);
    send_rect(0, 0);

    // zero columns: everything outside
    load_grid(0, 1, 1, 1);
    send_rect(0, 0);

    for (int unsigned ph = 0; ph < 7; ph++) begin
      if (ph == 6) calm = 1'b1;
      random_phase(ph, 44);
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("tb_crossed_quad_mesh_indexer passed");
    else
      $display("tb_crossed_quad_mesh_indexer failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/cqmi_pkg.sv
rtl/core/cqmi_if.sv
rtl/core/cqmi_front.sv
rtl/core/cqmi_queue.sv
rtl/core/cqmi_back.sv
rtl/core/crossed_quad_mesh_indexer.sv
tb/cqmi_mesh_checker.sv
tb/tb_crossed_quad_mesh_indexer.sv
